// ===== rtl/voxel_six_neighbour_count_unit_defines.svh =====
// assertion macros used by the voxel neighbour count rtl
`ifndef VOXEL_SIX_NEIGHBOUR_COUNT_UNIT_DEFINES_SVH
`define VOXEL_SIX_NEIGHBOUR_COUNT_UNIT_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define VXNC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define VXNC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/vxnc_pkg.sv =====
package vxnc_pkg;

    // grid edge; it fixes the 4-bit coordinate fields
    localparam int MAX_SIDE = 16;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W   = 5;
    localparam int ADDR_W   = 3 * COORD_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int CNT_W    = 3;
    localparam int STEP_W   = 3;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(16);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // neighbour visiting order
    localparam logic [STEP_W-1:0] STEP_K_DN = 3'd0;
    localparam logic [STEP_W-1:0] STEP_K_UP = 3'd1;
    localparam logic [STEP_W-1:0] STEP_J_DN = 3'd2;
    localparam logic [STEP_W-1:0] STEP_J_UP = 3'd3;
    localparam logic [STEP_W-1:0] STEP_I_DN = 3'd4;
    localparam logic [STEP_W-1:0] STEP_I_UP = 3'd5;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] k;
        logic [COORD_W-1:0] j;
        logic [COORD_W-1:0] i;
        logic [STEP_W-1:0]  step;
        logic [SIDE_W-1:0]  side;
    } nbr_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              inb;
    } nbr_rsp_t;

endpackage

// ===== rtl/vxnc_ram.sv =====
module vxnc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/vxnc_nbr_gen.sv =====
module vxnc_nbr_gen (
    input  vxnc_pkg::nbr_req_t req,
    output vxnc_pkg::nbr_rsp_t rsp
);
    import vxnc_pkg::*;

    logic [COORD_W-1:0] sel;
    logic [1:0]         axis;
    logic               dec;
    logic               step_ok;
    logic [SIDE_W-1:0]  sum;
    logic [COORD_W-1:0] k_n;
    logic [COORD_W-1:0] j_n;
    logic [COORD_W-1:0] i_n;

    always_comb
    begin
        sel     = req.k;
        axis    = 2'd0;
        dec     = 1'b0;
        step_ok = 1'b1;
        case (req.step)
            STEP_K_DN: begin sel = req.k; axis = 2'd0; dec = 1'b1; end
            STEP_K_UP: begin sel = req.k; axis = 2'd0; dec = 1'b0; end
            STEP_J_DN: begin sel = req.j; axis = 2'd1; dec = 1'b1; end
            STEP_J_UP: begin sel = req.j; axis = 2'd1; dec = 1'b0; end
            STEP_I_DN: begin sel = req.i; axis = 2'd2; dec = 1'b1; end
            STEP_I_UP: begin sel = req.i; axis = 2'd2; dec = 1'b0; end
            default:   step_ok = 1'b0;
        endcase

        // the one offset adder and the bound compares shared by all six neighbours
        sum = {1'b0, sel} + (dec ? {SIDE_W{1'b1}} : SIDE_W'(1));

        k_n = req.k;
        j_n = req.j;
        i_n = req.i;
        case (axis)
            2'd0:    k_n = sum[COORD_W-1:0];
            2'd1:    j_n = sum[COORD_W-1:0];
            default: i_n = sum[COORD_W-1:0];
        endcase

        rsp.addr = {k_n, j_n, i_n};
        rsp.inb  = step_ok && (dec ? (sel != '0) : (sum < req.side));
    end

endmodule

// ===== rtl/voxel_six_neighbour_count_unit.sv =====
// write request: no result, the next request can be taken in the following cycle
// in-cube query request: result registered after six mark reads in turn, with no new
//   request taken meanwhile; the reads go through the single read port of the grid memory
// a finished result that cannot enter the busy output holds all requests until the output frees
// reset (rst_n low, async) clears control and sets the side to 16, then a clearing
//   pass zeroes the 4096 marks one a cycle; requests are stalled until the pass ends
`include "voxel_six_neighbour_count_unit_defines.svh"

module voxel_six_neighbour_count_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [vxnc_pkg::SIDE_W-1:0]  cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic [vxnc_pkg::COORD_W-1:0] coord_k,
    input  logic [vxnc_pkg::COORD_W-1:0] coord_j,
    input  logic [vxnc_pkg::COORD_W-1:0] coord_i,
    input  logic                         occupied,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [vxnc_pkg::CNT_W-1:0]   neighbour_count,
    output logic                         coord_error
);
    import vxnc_pkg::*;

    state_t             state_reg, state_next;
    logic [SIDE_W-1:0]  side_reg;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               err_reg, err_next;
    logic [COORD_W-1:0] k_reg, j_reg, i_reg;
    logic               out_valid_reg;
    logic [CNT_W-1:0]   cnt_out_reg;
    logic               err_out_reg;

    logic [SIDE_W-1:0]  side_eff;
    logic               in_accept;
    logic               in_cube;
    logic               out_free;
    logic [CNT_W-1:0]   acc_sum;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_wdata;
    logic               ram_rdata;
    logic               out_load;
    logic [CNT_W-1:0]   out_cnt;
    logic               out_err;

    nbr_req_t           nreq;
    nbr_rsp_t           nrsp;

    assign side_eff  = (side_reg > SIDE_MAX) ? SIDE_MAX : side_reg;
    assign in_accept = in_valid && !in_stall;
    assign in_cube   = ({1'b0, coord_k} < side_eff) && ({1'b0, coord_j} < side_eff)
                    && ({1'b0, coord_i} < side_eff);
    assign out_free  = !out_valid_reg || !out_stall;
    assign acc_sum   = acc_reg + CNT_W'(rd_ok_reg & ram_rdata);

    assign nreq.k    = k_reg;
    assign nreq.j    = j_reg;
    assign nreq.i    = i_reg;
    assign nreq.step = step_reg;
    assign nreq.side = side_eff;

    vxnc_nbr_gen u_nbr (
        .req (nreq),
        .rsp (nrsp)
    );

    vxnc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (nrsp.addr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && cmd == CMD_QUERY)
                begin
                    if (in_cube)
                    begin
                        state_next = ST_QUERY;
                    end
                    else if (!out_free)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_QUERY:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = out_free ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = 1'b0;
        out_load  = 1'b0;
        out_cnt   = acc_reg;
        out_err   = err_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ram_waddr = {coord_k, coord_j, coord_i};
                ram_wdata = occupied;
                ram_we    = in_accept && cmd == CMD_WRITE && in_cube;
                // out-of-cube query answers at once when the output is free
                out_load  = in_accept && cmd == CMD_QUERY && !in_cube && out_free;
                out_cnt   = '0;
                out_err   = 1'b1;
            end
            ST_QUERY:
            begin
                out_load = (step_reg == STEP_LAST) && out_free;
                out_cnt  = acc_sum;
                out_err  = 1'b0;
            end
            ST_FINISH:
            begin
                out_load = out_free;
            end
            default: in_stall = 1'b1;
        endcase
    end

    // sequencer datapath
    always_comb
    begin
        clr_next   = clr_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        rd_ok_next = 1'b0;
        err_next   = err_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                step_next = '0;
                acc_next  = '0;
                err_next  = !in_cube;
            end
            ST_QUERY:
            begin
                // read issued now, its mark is counted next cycle
                acc_next   = acc_sum;
                rd_ok_next = nrsp.inb;
                if (step_reg != STEP_LAST)
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            side_reg      <= SIDE_RESET;
            clr_reg       <= '0;
            step_reg      <= '0;
            acc_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            step_reg  <= step_next;
            acc_reg   <= acc_next;
            rd_ok_reg <= rd_ok_next;
            err_reg   <= err_next;
            if (cfg_we)
            begin
                side_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            k_reg <= coord_k;
            j_reg <= coord_j;
            i_reg <= coord_i;
        end
        if (out_load)
        begin
            cnt_out_reg <= out_cnt;
            err_out_reg <= out_err;
        end
    end

    assign out_valid       = out_valid_reg;
    assign neighbour_count = cnt_out_reg;
    assign coord_error     = err_out_reg;

    `VXNC_ASSERT_NEXT(a_query_busy, in_accept && cmd == CMD_QUERY && in_cube,
        state_reg == ST_QUERY, "in-cube query did not start the neighbour sweep")
    `VXNC_ASSERT_ALWAYS(a_no_write_in_sweep, !(ram_we && state_reg == ST_QUERY),
        "grid write during neighbour sweep")
    `VXNC_ASSERT_ALWAYS(a_err_count_zero, !(out_valid && coord_error && neighbour_count != '0),
        "error result carries a nonzero count")
    `VXNC_ASSERT_ALWAYS(a_acc_range, acc_reg <= CNT_W'(6),
        "neighbour count above six")

endmodule

// ===== tb/tb_voxel_six_neighbour_count_unit.sv =====
`timescale 1ns / 1ps

module tb_voxel_six_neighbour_count_unit;

    import vxnc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    // margin after the results drain; leave room before touching the side register
    localparam int SETTLE_WAIT  = 16;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             err;
    } count_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [SIDE_W-1:0]   cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic                cmd;
    logic [COORD_W-1:0]  coord_k;
    logic [COORD_W-1:0]  coord_j;
    logic [COORD_W-1:0]  coord_i;
    logic                occupied;
    logic                out_valid;
    logic                out_stall;
    logic [CNT_W-1:0]    neighbour_count;
    logic                coord_error;

    // predictor state
    logic                mark_grid [DEPTH];
    logic [SIDE_W-1:0]   side_reg;
    count_result_t       expected_counts [$];
    count_result_t       oldest;

    int                  mismatches;
    int                  cycle_count;
    bit                  send_idle;
    bit                  recv_idle;

    voxel_six_neighbour_count_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .coord_k         (coord_k),
        .coord_j         (coord_j),
        .coord_i         (coord_i),
        .occupied        (occupied),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .neighbour_count (neighbour_count),
        .coord_error     (coord_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("voxel_six_neighbour_count_unit regression: fail");
            $finish;
        end
    end

    function automatic int cube_edge();
        return (side_reg > SIDE_MAX) ? MAX_SIDE : int'(side_reg);
    endfunction

    function automatic int mark_at(int k, int j, int i, int n);
        if (k < 0 || j < 0 || i < 0 || k >= n || j >= n || i >= n)
            return 0;
        return mark_grid[(k * MAX_SIDE + j) * MAX_SIDE + i] ? 1 : 0;
    endfunction

    // update the grid copy and queue the count that a query should return
    task automatic apply_request(input logic c, input int k, input int j, input int i,
                                 input logic occ);
        int            n;
        bit            in_cube;
        int            total;
        count_result_t res;
        n       = cube_edge();
        in_cube = (k < n) && (j < n) && (i < n);
        if (c == CMD_WRITE)
        begin
            if (in_cube)
                mark_grid[(k * MAX_SIDE + j) * MAX_SIDE + i] = occ;
        end
        else
        begin
            if (!in_cube)
            begin
                res.count = '0;
                res.err   = 1'b1;
            end
            else
            begin
                total = mark_at(k - 1, j, i, n) + mark_at(k + 1, j, i, n)
                      + mark_at(k, j - 1, i, n) + mark_at(k, j + 1, i, n)
                      + mark_at(k, j, i - 1, n) + mark_at(k, j, i + 1, n);
                res.count = CNT_W'(total);
                res.err   = 1'b0;
            end
            expected_counts.push_back(res);
        end
    endtask

    task automatic send_request(input logic c, input int k, input int j, input int i,
                                input logic occ);
        int gap;
        gap = send_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cmd      <= c;
        coord_k  <= COORD_W'(k);
        coord_j  <= COORD_W'(j);
        coord_i  <= COORD_W'(i);
        occupied <= occ;
        do @(posedge clk); while (in_stall);
        apply_request(c, k, j, i, occ);
    endtask

    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic set_side(input logic [SIDE_W-1:0] value);
        drain_block();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        side_reg = value;
    endtask

    // receiver: random stall before each result, sometimes none at all
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            gap = recv_idle ? $urandom_range(0, 14) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_counts.size() == 0)
            begin
                $error("result with no pending query: neighbour_count %0d, coord_error %0d",
                       neighbour_count, coord_error);
                mismatches++;
            end
            else
            begin
                oldest = expected_counts.pop_front();
                if (neighbour_count !== oldest.count)
                begin
                    $error("neighbour_count mismatch: expected %0d, actual %0d",
                           oldest.count, neighbour_count);
                    mismatches++;
                end
                if (coord_error !== oldest.err)
                begin
                    $error("coord_error mismatch: expected %0d, actual %0d",
                           oldest.err, coord_error);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_cleared_grid();
        send_request(CMD_QUERY, 0, 0, 0, 1'b0);
        send_request(CMD_QUERY, 15, 15, 15, 1'b1);
        send_request(CMD_QUERY, 7, 8, 9, 1'b0);
    endtask

    task automatic test_face_neighbours();
        // all six neighbours of an interior site
        send_request(CMD_WRITE, 4, 5, 5, 1'b1);
        send_request(CMD_WRITE, 6, 5, 5, 1'b1);
        send_request(CMD_WRITE, 5, 4, 5, 1'b1);
        send_request(CMD_WRITE, 5, 6, 5, 1'b1);
        send_request(CMD_WRITE, 5, 5, 4, 1'b1);
        send_request(CMD_WRITE, 5, 5, 6, 1'b1);
        send_request(CMD_QUERY, 5, 5, 5, 1'b1);
        send_request(CMD_WRITE, 5, 5, 4, 1'b0);
        send_request(CMD_QUERY, 5, 5, 5, 1'b0);
        // corners: half of the neighbours fall off the cube
        send_request(CMD_WRITE, 0, 0, 1, 1'b1);
        send_request(CMD_WRITE, 0, 1, 0, 1'b1);
        send_request(CMD_WRITE, 1, 0, 0, 1'b1);
        send_request(CMD_QUERY, 0, 0, 0, 1'b0);
        send_request(CMD_WRITE, 15, 15, 14, 1'b1);
        send_request(CMD_WRITE, 15, 14, 15, 1'b1);
        send_request(CMD_WRITE, 14, 15, 15, 1'b1);
        send_request(CMD_QUERY, 15, 15, 15, 1'b0);
    endtask

    task automatic test_small_sides();
        set_side(SIDE_W'(1));
        send_request(CMD_QUERY, 0, 0, 0, 1'b0);
        send_request(CMD_QUERY, 0, 0, 1, 1'b0);
        // outside the cube, must not clear the mark
        send_request(CMD_WRITE, 0, 0, 1, 1'b0);
        set_side(SIDE_W'(0));
        send_request(CMD_QUERY, 0, 0, 0, 1'b0);
        send_request(CMD_WRITE, 1, 0, 0, 1'b0);
        set_side(SIDE_W'(16));
        send_request(CMD_QUERY, 0, 0, 0, 1'b0);
    endtask

    task automatic test_oversize_side();
        set_side(SIDE_W'(31));
        send_request(CMD_QUERY, 15, 15, 15, 1'b0);
        send_request(CMD_QUERY, 5, 5, 5, 1'b0);
        set_side(SIDE_W'(17));
        send_request(CMD_QUERY, 15, 15, 15, 1'b0);
    endtask

    function automatic int pick_coord(int base, int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return (base + $urandom_range(0, 2) - 1) & (MAX_SIDE - 1);
        if (r < 85 && n > 0)
            return $urandom_range(0, n - 1);
        return $urandom_range(0, MAX_SIDE - 1);
    endfunction

    task automatic test_random_traffic();
        logic [SIDE_W-1:0] sides [11];
        int                n;
        int                count;
        int                bk, bj, bi;
        logic              c;
        sides[0] = SIDE_W'(16);
        sides[1] = SIDE_W'(31);
        sides[2] = SIDE_W'(1);
        sides[3] = SIDE_W'(0);
        sides[4] = SIDE_W'(20);
        for (int p = 5; p < 11; p++)
            sides[p] = SIDE_W'($urandom_range(2, 15));
        for (int p = 0; p < 11; p++)
        begin
            set_side(sides[p]);
            send_idle = (p % 4 != 1);
            recv_idle = (p % 4 != 1) && (p % 4 != 3);
            n     = cube_edge();
            count = (n <= 1) ? 50 : 200;
            bk = 0;
            bj = 0;
            bi = 0;
            for (int t = 0; t < count; t++)
            begin
                // move the dense cluster now and then
                if (t % 32 == 0 && n > 0)
                begin
                    bk = $urandom_range(0, n - 1);
                    bj = $urandom_range(0, n - 1);
                    bi = $urandom_range(0, n - 1);
                end
                c = $urandom_range(0, 1) ? CMD_QUERY : CMD_WRITE;
                send_request(c, pick_coord(bk, n), pick_coord(bj, n), pick_coord(bi, n),
                             logic'($urandom_range(0, 9) < 7));
            end
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        cmd       = CMD_WRITE;
        coord_k   = '0;
        coord_j   = '0;
        coord_i   = '0;
        occupied  = 1'b0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        mismatches  = 0;
        cycle_count = 0;
        side_reg    = SIDE_RESET;
        for (int a = 0; a < DEPTH; a++)
            mark_grid[a] = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_cleared_grid();
        test_face_neighbours();
        test_small_sides();
        test_oversize_side();
        test_random_traffic();

        drain_block();
        if (mismatches == 0)
            $display("voxel_six_neighbour_count_unit regression: pass");
        else
            $display("voxel_six_neighbour_count_unit regression: fail");
        $finish;
    end

endmodule

// ===== voxel_six_neighbour_count_unit.f =====
+incdir+rtl
rtl/vxnc_pkg.sv
rtl/vxnc_ram.sv
rtl/vxnc_nbr_gen.sv
rtl/voxel_six_neighbour_count_unit.sv
tb/tb_voxel_six_neighbour_count_unit.sv
